// File: rtl/tnep_pkg.sv
// Shared types, widths and helpers for the top-N edge pruner.
package tnep_pkg;

	localparam int KEEP_MAX = 16;
	localparam int ID_W     = 16;
	localparam int COEFF_W  = 32;
	localparam int KEEP_W   = 5;

	localparam logic [KEEP_W-1:0] KEEP_RESET = KEEP_W'(16);

	typedef logic [ID_W-1:0]           edge_id_t;
	typedef logic signed [COEFF_W-1:0] coeff_t;
	typedef logic [KEEP_W-1:0]         keep_t;

	// One stored edge.
	typedef struct packed {
		logic     valid;
		coeff_t   coeff;
		edge_id_t id;
	} entry_t;

	// Broadcast from the control to every cell.
	typedef struct packed {
		logic     ins;    // insert the offered edge this cycle
		logic     grow;   // the store may gain one entry
		logic     clr;    // node ends: empty the store
		coeff_t   coeff;
		edge_id_t id;
	} cell_cmd_t;

	// What a cell hands to its right neighbor.
	typedef struct packed {
		entry_t entry;
		logic   slot;     // offered edge goes at or before this cell
	} link_t;

	// Flip the sign bit so that an unsigned compare orders signed values.
	function automatic logic [COEFF_W-1:0] order_key(input coeff_t raw);
		order_key = {~raw[COEFF_W-1], raw[COEFF_W-2:0]};
	endfunction

endpackage

// File: rtl/tnep_if.sv
// Request and result channel interfaces of the top-N edge pruner.
interface tnep_edge_if;
	import tnep_pkg::*;

	logic     valid;
	logic     ready;
	edge_id_t edge_id;
	coeff_t   coeff_value;
	logic     last_edge;

	modport source (output valid, edge_id, coeff_value, last_edge, input ready);
	modport sink   (input valid, edge_id, coeff_value, last_edge, output ready);
endinterface

interface tnep_drop_if;
	import tnep_pkg::*;

	logic     valid;
	logic     ready;
	logic     drop_valid;
	edge_id_t drop_id;
	logic     node_done;

	modport source (output valid, drop_valid, drop_id, node_done, input ready);
	modport sink   (input valid, drop_valid, drop_id, node_done, output ready);
endinterface

// File: rtl/tnep_cell.sv
// One slot of the sorted store: compares against the offered edge and shifts.
module tnep_cell (
	input  logic                 clk,
	input  logic                 arst_n,
	input  tnep_pkg::cell_cmd_t  cmd,
	input  tnep_pkg::link_t      left,
	output tnep_pkg::link_t      right
);
	import tnep_pkg::*;

	logic     valid_q;
	coeff_t   coeff_q;
	edge_id_t id_q;
	logic     beat;
	logic     slot;
	logic     take_new;
	logic     take_left;

	// Strictly higher only: a tie leaves the offered edge behind this one.
	assign beat      = valid_q && (order_key(cmd.coeff) > order_key(coeff_q));
	assign slot      = !valid_q || beat;
	assign take_new  = cmd.ins && slot && !left.slot;
	assign take_left = cmd.ins && left.slot;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (cmd.clr) begin
			valid_q <= 1'b0;
		end else if (take_new) begin
			valid_q <= valid_q || cmd.grow;
		end else if (take_left) begin
			valid_q <= valid_q || (cmd.grow && left.entry.valid);
		end
	end

	always_ff @(posedge clk) begin
		if (take_new) begin
			coeff_q <= cmd.coeff;
			id_q    <= cmd.id;
		end else if (take_left) begin
			coeff_q <= left.entry.coeff;
			id_q    <= left.entry.id;
		end
	end

	assign right.entry = '{valid: valid_q, coeff: coeff_q, id: id_q};
	assign right.slot  = slot;

endmodule

// File: rtl/top_n_edge_pruner.sv
// Top level of the top-N edge pruner: cell chain, decision logic, result register.
//
// Usage:
//   edges  - request channel; each request is one edge of the current node
//            (edge_id, coeff_value as signed Q2.30, last_edge marking the
//            node's final edge).
//   drops  - result channel; one result per request: drop_valid/drop_id
//            name the edge to remove (drop_id is zero when nothing is
//            dropped), node_done repeats last_edge.
//   cfg_we/cfg_wdata - write keep_count (0..16, larger values act as 16);
//            write only while no request is in flight.
// The store is a row of KEEP_MAX cells kept sorted, highest coefficient
// first. Every request is compared against all cells at once and the row
// shifts right past the insert point in the same cycle.
// The result is registered and appears in the cycle after the request is accepted.
// Throughput: one request per cycle while results are taken, set by the single
// compare-and-shift pass across the cell row and the one-entry result register.
// Reset clears the store and sets keep_count to 16. When the receiver stalls
// the result register holds its result and edges.ready drops, so no request
// is taken until the held result leaves; a result taken in a cycle frees
// the register for a new request in that same cycle.
module top_n_edge_pruner (
	input  logic               clk,
	input  logic               arst_n,
	tnep_edge_if.sink          edges,
	tnep_drop_if.source        drops,
	input  logic               cfg_we,
	input  tnep_pkg::keep_t    cfg_wdata
);
	import tnep_pkg::*;

	keep_t     keep_q;
	cell_cmd_t cmd;
	link_t     chain [0:KEEP_MAX];

	logic      accept;
	logic      full;
	logic      empty;
	logic      tail_beaten;
	edge_id_t  tail_id;
	logic      is_tail;
	int        cap;

	logic      drop_now;
	edge_id_t  drop_id_now;

	logic      out_valid_q;
	logic      drop_valid_q;
	edge_id_t  drop_id_q;
	logic      node_done_q;

	// Keep count register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			keep_q <= KEEP_RESET;
		end else if (cfg_we) begin
			keep_q <= cfg_wdata;
		end
	end

	// Take a request whenever the result register is free or being emptied.
	assign edges.ready = !out_valid_q || drops.ready;
	assign accept      = edges.valid && edges.ready;

	// Valid entries form a prefix, so "full" means cap is zero or some valid cell reaches cap.
	always_comb begin
		cap = (int'(keep_q) > KEEP_MAX) ? KEEP_MAX : int'(keep_q);
		full        = (cap == 0);
		tail_beaten = 1'b0;
		tail_id     = '0;
		is_tail     = 1'b0;
		for (int i = 0; i < KEEP_MAX; i++) begin
			if (chain[i+1].entry.valid && (i + 1 >= cap)) begin
				full = 1'b1;
			end
			if (i == KEEP_MAX - 1) begin
				is_tail = chain[i+1].entry.valid;
			end else begin
				is_tail = chain[i+1].entry.valid && !chain[i+2].entry.valid;
			end
			if (is_tail) begin
				tail_id     = tail_id | chain[i+1].entry.id;
				tail_beaten = tail_beaten | chain[i+1].slot;
			end
		end
	end

	assign empty = !chain[1].entry.valid;

	// Decide per request: grow, replace the lowest entry, or drop the request.
	always_comb begin
		cmd.coeff   = edges.coeff_value;
		cmd.id      = edges.edge_id;
		cmd.clr     = accept && edges.last_edge;
		cmd.ins     = 1'b0;
		cmd.grow    = 1'b0;
		drop_now    = 1'b0;
		drop_id_now = '0;
		priority if (!full) begin
			cmd.ins  = accept;
			cmd.grow = 1'b1;
		end else if (empty) begin
			drop_now    = 1'b1;
			drop_id_now = edges.edge_id;
		end else if (tail_beaten) begin
			// Push out the lowest entry and insert in its place.
			cmd.ins     = accept;
			drop_now    = 1'b1;
			drop_id_now = tail_id;
		end else begin
			drop_now    = 1'b1;
			drop_id_now = edges.edge_id;
		end
	end

	// Left end of the row: nothing valid, offered edge never goes before it.
	assign chain[0] = '0;

	for (genvar g = 0; g < KEEP_MAX; g++) begin : g_cell
		tnep_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.cmd    (cmd),
			.left   (chain[g]),
			.right  (chain[g+1])
		);
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (drops.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			drop_valid_q <= drop_now;
			drop_id_q    <= drop_id_now;
			node_done_q  <= edges.last_edge;
		end
	end

	assign drops.valid      = out_valid_q;
	assign drops.drop_valid = drop_valid_q;
	assign drops.drop_id    = drop_id_q;
	assign drops.node_done  = node_done_q;

endmodule

// File: rtl/tnep_checker.sv
// Port-level checks for the top-N edge pruner, bound to the top level.
module tnep_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input logic               in_last,
	input logic               out_valid,
	input logic               out_ready,
	input logic               out_drop_valid,
	input tnep_pkg::edge_id_t out_drop_id,
	input logic               out_node_done
);
	import tnep_pkg::*;

	// Hold a stalled result.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	// Stop taking requests while a result is stalled.
	a_no_take_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |-> !in_ready)
		else $error("request taken while result stalled");

	// Every accepted request yields a result in the next cycle.
	a_one_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> out_valid && (out_node_done == $past(in_last)))
		else $error("result missing or node_done wrong");

	// A result that removes nothing carries a zero id.
	a_zero_id: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> out_drop_valid || (out_drop_id == '0))
		else $error("nonzero drop_id without drop_valid");

endmodule

bind top_n_edge_pruner tnep_checker u_tnep_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.in_valid       (edges.valid),
	.in_ready       (edges.ready),
	.in_last        (edges.last_edge),
	.out_valid      (drops.valid),
	.out_ready      (drops.ready),
	.out_drop_valid (drops.drop_valid),
	.out_drop_id    (drops.drop_id),
	.out_node_done  (drops.node_done)
);

// File: dv/top_n_edge_pruner_tb.sv
// Self-checking testbench for the top-N edge pruner: random requests, stalls, top-N prediction.
`timescale 1ns / 100ps

module top_n_edge_pruner_tb;
	import tnep_pkg::*;

	// Quiet cycles with nothing accepted before the run is declared hung.
	localparam int HANG_LIMIT = 2000;
	// Receiver hold-off long enough to back the block up into its request side.
	localparam int LONG_HOLD  = 300;
	localparam int PHASE_EDGES = 200;

	typedef struct {
		edge_id_t id;
		coeff_t   coeff;
		logic     last;
	} edge_req_t;

	typedef struct packed {
		logic     drop_valid;
		edge_id_t drop_id;
		logic     node_done;
	} drop_t;

	logic  clk = 1'b0;
	logic  arst_n = 1'b0;
	logic  cfg_we = 1'b0;
	keep_t cfg_wdata = '0;

	tnep_edge_if edges_if ();
	tnep_drop_if drops_if ();

	top_n_edge_pruner dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.edges    (edges_if),
		.drops    (drops_if),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	always #5 clk = ~clk;

	// Requests waiting to be offered, and results the block still owes us.
	edge_req_t edge_queue[$];
	drop_t     drop_queue[$];

	// Shadow of the block: sorted survivors of the current node, best first.
	coeff_t   kept_coeff[KEEP_MAX];
	edge_id_t kept_id[KEEP_MAX];
	int       kept_n = 0;
	keep_t    keep_cfg = KEEP_RESET;

	int    errors = 0;
	int    edges_taken = 0;
	int    nodes_closed = 0;
	int    removals = 0;
	int    settings_used = 1;
	int    node_left = 0;
	int    src_gap = 0;
	int    sink_hold = 0;
	int    quiet_cycles = 0;
	logic  calm = 1'b0;       // no idling on either side once set
	logic  stall_ask = 1'b0;  // ask the receiver for one long hold-off

	// Slot a new edge in behind every kept edge that is at least as good,
	// so that a tie leaves the earlier edge ahead.
	function automatic void slot_edge(edge_id_t id, coeff_t coeff);
		int pos;
		pos = kept_n;
		while (pos > 0 && kept_coeff[pos - 1] < coeff) begin
			kept_coeff[pos] = kept_coeff[pos - 1];
			kept_id[pos]    = kept_id[pos - 1];
			pos--;
		end
		kept_coeff[pos] = coeff;
		kept_id[pos]    = id;
		kept_n++;
	endfunction

	// Decide the fate of one offered edge and update the shadow store.
	function automatic drop_t prune_edge(edge_id_t id, coeff_t coeff, logic last);
		drop_t verdict;
		int    cap;
		verdict = '0;
		cap = (int'(keep_cfg) > KEEP_MAX) ? KEEP_MAX : int'(keep_cfg);
		if (kept_n < cap) begin
			slot_edge(id, coeff);
		end else if (kept_n == 0) begin
			// nothing may be kept: the edge itself goes
			verdict.drop_valid = 1'b1;
			verdict.drop_id    = id;
		end else if (coeff > kept_coeff[kept_n - 1]) begin
			// evict the weakest survivor to make room
			verdict.drop_valid = 1'b1;
			verdict.drop_id    = kept_id[kept_n - 1];
			kept_n--;
			slot_edge(id, coeff);
		end else begin
			verdict.drop_valid = 1'b1;
			verdict.drop_id    = id;
		end
		// close the node: survivors are kept silently
		if (last)
			kept_n = 0;
		verdict.node_done = last;
		return verdict;
	endfunction

	// Mix wide random values with near-zero values (ties) and the range ends.
	function automatic coeff_t pick_coeff();
		case ($urandom_range(0, 4))
			0: return coeff_t'(int'($urandom_range(0, 6)) - 3);
			1: begin
				case ($urandom_range(0, 3))
					0: return coeff_t'(32'h8000_0000);
					1: return coeff_t'(32'h7FFF_FFFF);
					2: return coeff_t'(32'h8000_0001);
					default: return coeff_t'(32'h7FFF_FFFE);
				endcase
			end
			default: return coeff_t'($urandom);
		endcase
	endfunction

	task automatic add_edge(edge_id_t id, coeff_t coeff, logic last);
		edge_req_t req;
		req = '{id, coeff, last};
		edge_queue.insert(edge_queue.size(), req);
	endtask

	// Append edges of nodes of random length; a node may run across phases,
	// so a later keep_count write can land in the middle of one.
	task automatic queue_random(int count);
		int k;
		for (k = 0; k < count; k++) begin
			if (node_left == 0)
				node_left = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 4)
				                                        : $urandom_range(5, 40);
			node_left--;
			add_edge(edge_id_t'($urandom), pick_coeff(), node_left == 0);
		end
	endtask

	// Wait until every request has gone in and every result has come out,
	// then let the result register settle.
	task automatic wait_drained();
		while (edge_queue.size() != 0 || drop_queue.size() != 0 || edges_if.valid)
			@(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	// Write keep_count while the block is idle; track it in the shadow.
	task automatic write_keep(keep_t value);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		keep_cfg  = value;
		settings_used++;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// Request driver: hold an offered request until taken, idle in bursts.
	always @(posedge clk) begin
		logic moved;
		moved = edges_if.valid && edges_if.ready;
		if (moved)
			edge_queue.delete(0);
		if (!arst_n) begin
			edges_if.valid <= 1'b0;
		end else if (edges_if.valid && !moved) begin
			// hold: the block has not taken it yet
		end else if (src_gap > 0) begin
			src_gap--;
			edges_if.valid <= 1'b0;
		end else if (!calm && edge_queue.size() != 0 && $urandom_range(0, 9) == 0) begin
			src_gap = $urandom_range(1, 14) - 1;
			edges_if.valid <= 1'b0;
		end else if (edge_queue.size() != 0) begin
			edges_if.valid       <= 1'b1;
			edges_if.edge_id     <= edge_queue[0].id;
			edges_if.coeff_value <= edge_queue[0].coeff;
			edges_if.last_edge   <= edge_queue[0].last;
		end else begin
			edges_if.valid <= 1'b0;
		end
	end

	// Result receiver: random short stalls plus one long hold-off on request.
	always @(posedge clk) begin
		if (!arst_n) begin
			drops_if.ready <= 1'b0;
		end else if (stall_ask) begin
			stall_ask      <= 1'b0;
			sink_hold      = LONG_HOLD - 1;
			drops_if.ready <= 1'b0;
		end else if (sink_hold > 0) begin
			sink_hold--;
			drops_if.ready <= 1'b0;
		end else if (!calm && $urandom_range(0, 9) == 0) begin
			sink_hold      = $urandom_range(1, 14) - 1;
			drops_if.ready <= 1'b0;
		end else begin
			drops_if.ready <= 1'b1;
		end
	end

	// Monitor: check each result against the oldest expectation, then
	// predict the result of any request taken at this edge.
	always @(posedge clk) begin
		drop_t want;
		if (arst_n) begin
			if (drops_if.valid && drops_if.ready) begin
				if (drop_queue.size() == 0) begin
					$error("unexpected result: drop_valid %0b drop_id %h node_done %0b",
					       drops_if.drop_valid, drops_if.drop_id, drops_if.node_done);
					errors++;
				end else begin
					want = drop_queue.pop_front();
					if (drops_if.drop_valid !== want.drop_valid) begin
						$error("drop_valid: expected %0b, got %0b",
						       want.drop_valid, drops_if.drop_valid);
						errors++;
					end
					if (drops_if.drop_id !== want.drop_id) begin
						$error("drop_id: expected %h, got %h", want.drop_id, drops_if.drop_id);
						errors++;
					end
					if (drops_if.node_done !== want.node_done) begin
						$error("node_done: expected %0b, got %0b",
						       want.node_done, drops_if.node_done);
						errors++;
					end
					if (want.drop_valid)
						removals++;
					if (want.node_done)
						nodes_closed++;
				end
			end
			if (edges_if.valid && edges_if.ready) begin
				drop_queue.insert(drop_queue.size(),
				                  prune_edge(edges_if.edge_id, edges_if.coeff_value,
				                             edges_if.last_edge));
				edges_taken++;
			end
		end
	end

	// Watchdog: too long without any handshake means the block is stuck.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((edges_if.valid && edges_if.ready) || (drops_if.valid && drops_if.ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= HANG_LIMIT) begin
				$display("hung for %0d cycles with %0d requests pending, %0d results owed",
				         quiet_cycles, edge_queue.size(), drop_queue.size());
				$display("status: fail");
				$finish;
			end
		end
	end

	initial begin
		keep_t phase_keep[10];
		int    k;
		int    p;

		edges_if.valid       = 1'b0;
		edges_if.edge_id     = '0;
		edges_if.coeff_value = '0;
		edges_if.last_edge   = 1'b0;
		drops_if.ready       = 1'b0;
		phase_keep = '{5'd31, 5'd1, 5'd0, 5'd5, 5'd17, 5'd2, 5'd9, 5'd12, 5'd3, 5'd16};

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// Fill all 16 places at the reset setting: range ends, ties, id ends.
		for (k = 0; k < KEEP_MAX; k++)
			add_edge(edge_id_t'(k * 16'h1111),
			         (k == 0) ? coeff_t'(32'h7FFF_FFFF) :
			         (k == 1) ? coeff_t'(32'h8000_0000) : coeff_t'((k % 4) - 2),
			         1'b0);
		// Tie with the weakest survivor: the newcomer loses.
		add_edge(16'hABCD, coeff_t'(32'h8000_0000), 1'b0);
		// Beat the weakest survivor, and close the node.
		add_edge(16'h5555, coeff_t'(1), 1'b1);
		wait_drained();

		// Keep nothing: every edge is removed at once.
		write_keep(5'd0);
		add_edge(16'h0042, coeff_t'(32'h7FFF_FFFF), 1'b0);
		add_edge(16'h0043, coeff_t'(0), 1'b1);
		wait_drained();

		// Lower keep_count mid-node: the three kept entries stay and act as full.
		write_keep(5'd3);
		add_edge(16'h0101, coeff_t'(10), 1'b0);
		add_edge(16'h0102, coeff_t'(20), 1'b0);
		add_edge(16'h0103, coeff_t'(30), 1'b0);
		wait_drained();
		write_keep(5'd1);
		add_edge(16'h0104, coeff_t'(25), 1'b0);
		add_edge(16'h0105, coeff_t'(5), 1'b1);
		wait_drained();

		// Random phases, one keep_count setting each, writes only when drained.
		for (p = 0; p < 10; p++) begin
			write_keep(phase_keep[p]);
			if (p == 9)
				calm <= 1'b1;
			queue_random(PHASE_EDGES);
			// Back the block up once while the driver keeps offering.
			if (p == 1)
				stall_ask <= 1'b1;
			wait_drained();
		end
		repeat (3) @(posedge clk);

		$display("covered %0d edges in %0d closed nodes, %0d removals reported",
		         edges_taken, nodes_closed, removals);
		$display("keep_count took %0d settings, from 0 up to saturation at 31", settings_used);
		if (errors == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

// File: sim.f
rtl/tnep_pkg.sv
rtl/tnep_if.sv
rtl/tnep_cell.sv
rtl/top_n_edge_pruner.sv
rtl/tnep_checker.sv
dv/top_n_edge_pruner_tb.sv
